[rtl/ffha_pkg.sv]
package ffha_pkg;

   localparam int OFFSET_BITS        = 24;
   localparam int SIZE_BITS          = 25;
   localparam int NEED_BITS          = 26;
   localparam int STAT_COUNT_BITS    = 7;
   localparam int MAX_BLOCKS_DEF     = 64;
   localparam int HEADER_BYTES_DEF   = 32;
   localparam int ALIGN_BYTES_DEF    = 16;
   localparam logic [SIZE_BITS-1:0] HEAP_MIN_BYTES     = 25'd4194304;
   localparam logic [SIZE_BITS-1:0] HEAP_MAX_BYTES     = 25'd16777216;
   localparam logic [SIZE_BITS-1:0] HEAP_DEFAULT_BYTES = 25'd16777216;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ZERO_SIZE  = 3'd1,
      ST_NO_MEMORY  = 3'd2,
      ST_OUTSIDE    = 3'd3,
      ST_NOT_BLOCK  = 3'd4,
      ST_DOUBLE     = 3'd5
   } status_type;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // one block descriptor as held in the table memory
   typedef struct packed {
      logic                   is_free;
      logic [SIZE_BITS-1:0]   size;
      logic [OFFSET_BITS-1:0] start;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [2:0] {
      SOP_NONE        = 3'd0,
      SOP_INIT        = 3'd1,
      SOP_ALLOC_SPLIT = 3'd2,
      SOP_ALLOC_WHOLE = 3'd3,
      SOP_FREE        = 3'd4
   } stat_op_type;

   typedef struct packed {
      stat_op_type          op;
      logic [SIZE_BITS-1:0] amount;
      logic                 merge_next;
      logic                 merge_prev;
   } stat_upd_type;

endpackage

[rtl/ffha_req_if.sv]
interface ffha_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic [ffha_pkg::SIZE_BITS-1:0]       req_size;
   logic [ffha_pkg::OFFSET_BITS-1:0]     req_addr;

   modport source (output valid, output req_type, output req_size, output req_addr,
                   input ready);
   modport sink   (input valid, input req_type, input req_size, input req_addr,
                   output ready);
endinterface

[rtl/ffha_rsp_if.sv]
interface ffha_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [2:0]                             status;
   logic [ffha_pkg::OFFSET_BITS-1:0]       addr;
   logic [ffha_pkg::SIZE_BITS-1:0]         used_bytes;
   logic [ffha_pkg::SIZE_BITS-1:0]         free_bytes;
   logic [ffha_pkg::STAT_COUNT_BITS-1:0]   block_count;
   logic [ffha_pkg::STAT_COUNT_BITS-1:0]   free_block_count;

   modport source (output valid, output status, output addr, output used_bytes,
                   output free_bytes, output block_count, output free_block_count,
                   input ready);
   modport sink   (input valid, input status, input addr, input used_bytes,
                   input free_bytes, input block_count, input free_block_count,
                   output ready);
endinterface

[rtl/ffha_ram.sv]
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/ffha_stats.sv]
module ffha_stats #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ffha_pkg::stat_upd_type            upd,
   output logic [ffha_pkg::SIZE_BITS-1:0]    used_total,
   output logic [ffha_pkg::SIZE_BITS-1:0]    free_total,
   output logic [$clog2(MAX_BLOCKS+1)-1:0]   block_total,
   output logic [$clog2(MAX_BLOCKS+1)-1:0]   free_block_total
);
   localparam int CW = $clog2(MAX_BLOCKS+1);
   localparam int SB = ffha_pkg::SIZE_BITS;

   logic [SB-1:0] used_ff, used_in, free_ff, free_in;
   logic [CW-1:0] blk_ff, blk_in, fblk_ff, fblk_in;
   logic [CW-1:0] merges;
   logic [SB-1:0] merge_hdr;

   always_comb begin
      used_in   = used_ff;
      free_in   = free_ff;
      blk_in    = blk_ff;
      fblk_in   = fblk_ff;
      merges    = CW'(upd.merge_next) + CW'(upd.merge_prev);
      merge_hdr = (upd.merge_next ? SB'(HEADER_BYTES) : '0)
                + (upd.merge_prev ? SB'(HEADER_BYTES) : '0);
      case (upd.op)
         ffha_pkg::SOP_INIT: begin
            used_in = '0;
            free_in = upd.amount;
            blk_in  = CW'(1);
            fblk_in = CW'(1);
         end
         ffha_pkg::SOP_ALLOC_SPLIT: begin
            used_in = used_ff + upd.amount;
            free_in = free_ff - upd.amount - SB'(HEADER_BYTES);
            blk_in  = blk_ff + CW'(1);
         end
         ffha_pkg::SOP_ALLOC_WHOLE: begin
            used_in = used_ff + upd.amount;
            free_in = free_ff - upd.amount;
            fblk_in = fblk_ff - CW'(1);
         end
         ffha_pkg::SOP_FREE: begin
            used_in = used_ff - upd.amount;
            free_in = free_ff + upd.amount + merge_hdr;
            blk_in  = blk_ff - merges;
            fblk_in = fblk_ff + CW'(1) - merges;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         free_ff <= ffha_pkg::HEAP_DEFAULT_BYTES - SB'(HEADER_BYTES);
         blk_ff  <= CW'(1);
         fblk_ff <= CW'(1);
      end else begin
         used_ff <= used_in;
         free_ff <= free_in;
         blk_ff  <= blk_in;
         fblk_ff <= fblk_in;
      end
   end

   assign used_total       = used_ff;
   assign free_total       = free_ff;
   assign block_total      = blk_ff;
   assign free_block_total = fblk_ff;
endmodule

[rtl/first_fit_heap_allocator_unit.sv]
// Channel   Dir  Payload                                          Transaction
// req_chan  in   req_type, req_size, req_addr                     valid & ready
// rsp_chan  out  status, addr, used/free bytes, block counts      valid & ready
// csr_*     in   csr_write_data (heap size in bytes)              csr_write_en
//
// One request is worked at a time. The block table sits in a single
// 1R1W RAM; a scan reads one descriptor per cycle. A request that finds its
// block goes through the scan (for a free, a look at the next block), the
// move of the table tail, one or two fix-up writes and the response load;
// the hit index plus the number of moved entries stays below MAX_BLOCKS.
// After reset the S_INIT state writes the initial descriptor before
// req_chan.ready rises. A stalled response is held in its output register;
// the next request waits until the response slot is free again.
module first_fit_heap_allocator_unit #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [ffha_pkg::SIZE_BITS-1:0]  csr_write_data,
   ffha_req_if.sink                        req_chan,
   ffha_rsp_if.source                      rsp_chan
);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS+1);
   localparam int SB = ffha_pkg::SIZE_BITS;
   localparam int OB = ffha_pkg::OFFSET_BITS;
   localparam int NB = ffha_pkg::NEED_BITS;

   typedef enum logic [8:0] {
      S_INIT  = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_ASCAN = 9'b000000100,
      S_FSCAN = 9'b000001000,
      S_FNEXT = 9'b000010000,
      S_SHIFT = 9'b000100000,
      S_FIX0  = 9'b001000000,
      S_FIX1  = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [SB-1:0]             heap_ff, heap_in, heap_clamped;
   logic [NB-1:0]             need_ff, need_in;
   logic [OB-1:0]             off_ff, off_in;
   logic [CW-1:0]             rd_idx_ff, rd_idx_in;
   logic                      pend_ff, pend_in;
   logic [IW-1:0]             pend_idx_ff, pend_idx_in;
   logic [IW-1:0]             hit_idx_ff, hit_idx_in;
   ffha_pkg::entry_type       hit_ent_ff, hit_ent_in;
   ffha_pkg::entry_type       prev_ent_ff, prev_ent_in;
   logic                      has_next_ff, has_next_in;
   // table tail move
   logic [IW-1:0]             sh_k_ff, sh_k_in;
   logic [CW-1:0]             sh_cnt_ff, sh_cnt_in;
   logic                      sh_up_ff, sh_up_in;
   logic [1:0]                sh_dist_ff, sh_dist_in;
   logic                      sw_v_ff, sw_v_in;
   logic [IW-1:0]             sw_addr_ff, sw_addr_in;
   // descriptors written once the move is done
   logic [IW-1:0]             fix0_addr_ff, fix0_addr_in, fix1_addr_ff, fix1_addr_in;
   ffha_pkg::entry_type       fix0_ff, fix0_in, fix1_ff, fix1_in;
   logic                      fix1_en_ff, fix1_en_in;
   ffha_pkg::status_type      status_ff, status_in;
   logic [OB-1:0]             res_addr_ff, res_addr_in;
   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   ffha_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [OB-1:0]             rsp_addr_ff, rsp_addr_in;

   logic                      ram_we;
   logic [IW-1:0]             ram_waddr, ram_raddr;
   ffha_pkg::entry_type       ram_wdata, ram_rdata;
   logic [ffha_pkg::ENTRY_BITS-1:0] ram_rdata_raw;

   ffha_pkg::stat_upd_type    upd;
   logic [SB-1:0]             used_total, free_total;
   logic [CW-1:0]             blk_total, fblk_total;

   logic                      req_acc;
   logic                      last_pend;
   logic [SB-1:0]             cur_size;
   logic [IW-1:0]             src_idx;
   logic                      mn, mp;

   ffha_ram #(.WIDTH(ffha_pkg::ENTRY_BITS), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );
   assign ram_rdata = ram_rdata_raw;

   ffha_stats #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_stats (
      .clock            (clock),
      .reset            (reset),
      .upd              (upd),
      .used_total       (used_total),
      .free_total       (free_total),
      .block_total      (blk_total),
      .free_block_total (fblk_total)
   );

   always_comb begin
      if (csr_write_data < ffha_pkg::HEAP_MIN_BYTES) begin
         heap_clamped = ffha_pkg::HEAP_MIN_BYTES;
      end else if (csr_write_data > ffha_pkg::HEAP_MAX_BYTES) begin
         heap_clamped = ffha_pkg::HEAP_MAX_BYTES;
      end else begin
         heap_clamped = csr_write_data;
      end
   end

   // a new request only once the previous response has left, so the live
   // statistics cannot move under a waiting response
   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_acc        = req_chan.valid && (state_ff == S_IDLE) && !rsp_valid_ff;
   assign last_pend      = (CW'(pend_idx_ff) + CW'(1)) == blk_total;

   always_comb begin
      state_in     = state_ff;
      heap_in      = heap_ff;
      need_in      = need_ff;
      off_in       = off_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = rd_idx_ff[IW-1:0];
      hit_idx_in   = hit_idx_ff;
      hit_ent_in   = hit_ent_ff;
      prev_ent_in  = prev_ent_ff;
      has_next_in  = has_next_ff;
      sh_k_in      = sh_k_ff;
      sh_cnt_in    = sh_cnt_ff;
      sh_up_in     = sh_up_ff;
      sh_dist_in   = sh_dist_ff;
      sw_v_in      = 1'b0;
      sw_addr_in   = sw_addr_ff;
      fix0_addr_in = fix0_addr_ff;
      fix1_addr_in = fix1_addr_ff;
      fix0_in      = fix0_ff;
      fix1_in      = fix1_ff;
      fix1_en_in   = fix1_en_ff;
      status_in    = status_ff;
      res_addr_in  = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = rd_idx_ff[IW-1:0];
      upd          = '{op: ffha_pkg::SOP_NONE, amount: '0, merge_next: 1'b0,
                       merge_prev: 1'b0};
      mn           = 1'b0;
      mp           = 1'b0;
      cur_size     = '0;
      src_idx      = '0;

      case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = '{is_free: 1'b1, size: heap_ff - SB'(HEADER_BYTES), start: '0};
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            rd_idx_in   = '0;
            res_addr_in = '0;
            if (req_acc) begin
               need_in = NB'(((27'(req_chan.req_size) + 27'(ALIGN_BYTES - 1))
                              / ALIGN_BYTES) * ALIGN_BYTES);
               off_in  = req_chan.req_addr;
               status_in = ffha_pkg::ST_OK;
               if (req_chan.req_type == ffha_pkg::REQ_ALLOC) begin
                  if (req_chan.req_size == '0) begin
                     status_in = ffha_pkg::ST_ZERO_SIZE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_ASCAN;
                  end
               end else if (SB'(req_chan.req_addr) >= heap_ff) begin
                  status_in = ffha_pkg::ST_OUTSIDE;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_FSCAN;
               end
            end
         end
         S_ASCAN, S_FSCAN: begin
            // one read issued per cycle, checked the cycle after
            if (rd_idx_ff < blk_total) begin
               pend_in   = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (pend_ff) begin
               if (state_ff == S_ASCAN) begin
                  if (ram_rdata.is_free && NB'(ram_rdata.size) >= need_ff) begin
                     pend_in      = 1'b0;
                     fix0_addr_in = pend_idx_ff;
                     res_addr_in  = ram_rdata.start + OB'(HEADER_BYTES);
                     state_in     = S_SHIFT;
                     if ((27'(ram_rdata.size) >= 27'(need_ff)
                          + 27'(HEADER_BYTES + ALIGN_BYTES))
                         && (blk_total < CW'(MAX_BLOCKS))) begin
                        fix0_in      = '{is_free: 1'b0, size: SB'(need_ff),
                                         start: ram_rdata.start};
                        fix1_en_in   = 1'b1;
                        fix1_addr_in = pend_idx_ff + IW'(1);
                        fix1_in      = '{is_free: 1'b1,
                                         size: ram_rdata.size - SB'(need_ff)
                                               - SB'(HEADER_BYTES),
                                         start: ram_rdata.start + OB'(HEADER_BYTES)
                                                + OB'(need_ff)};
                        sh_up_in   = 1'b1;
                        sh_dist_in = 2'd1;
                        sh_k_in    = IW'(blk_total - CW'(1));
                        sh_cnt_in  = blk_total - CW'(pend_idx_ff) - CW'(1);
                        upd.op     = ffha_pkg::SOP_ALLOC_SPLIT;
                        upd.amount = SB'(need_ff);
                     end else begin
                        fix0_in         = ram_rdata;
                        fix0_in.is_free = 1'b0;
                        fix1_en_in      = 1'b0;
                        sh_cnt_in       = '0;
                        upd.op          = ffha_pkg::SOP_ALLOC_WHOLE;
                        upd.amount      = ram_rdata.size;
                     end
                  end else if (last_pend) begin
                     status_in = ffha_pkg::ST_NO_MEMORY;
                     state_in  = S_RESP;
                  end
               end else begin
                  if (SB'(ram_rdata.start) + SB'(HEADER_BYTES) == SB'(off_ff)) begin
                     pend_in = 1'b0;
                     if (ram_rdata.is_free) begin
                        status_in = ffha_pkg::ST_DOUBLE;
                        state_in  = S_RESP;
                     end else begin
                        hit_idx_in  = pend_idx_ff;
                        hit_ent_in  = ram_rdata;
                        has_next_in = !last_pend;
                        state_in    = S_FNEXT;
                     end
                  end else begin
                     prev_ent_in = ram_rdata;
                     if (last_pend) begin
                        status_in = ffha_pkg::ST_NOT_BLOCK;
                        state_in  = S_RESP;
                     end
                  end
               end
            end
         end
         S_FNEXT: begin
            // read data now holds the following block, if any
            mn       = has_next_ff && ram_rdata.is_free;
            mp       = (hit_idx_ff != '0) && prev_ent_ff.is_free;
            cur_size = hit_ent_ff.size
                     + (mn ? (ram_rdata.size + SB'(HEADER_BYTES)) : '0);
            if (mp) begin
               fix0_addr_in = hit_idx_ff - IW'(1);
               fix0_in      = '{is_free: 1'b1,
                                size: prev_ent_ff.size + SB'(HEADER_BYTES) + cur_size,
                                start: prev_ent_ff.start};
            end else begin
               fix0_addr_in = hit_idx_ff;
               fix0_in      = '{is_free: 1'b1, size: cur_size, start: hit_ent_ff.start};
            end
            fix1_en_in = 1'b0;
            src_idx    = hit_idx_ff + IW'(1) + IW'(mn);
            sh_up_in   = 1'b0;
            sh_dist_in = 2'(mn) + 2'(mp);
            sh_k_in    = src_idx;
            sh_cnt_in  = (mn || mp) ? (blk_total - CW'(hit_idx_ff) - CW'(1) - CW'(mn))
                                    : '0;
            upd.op         = ffha_pkg::SOP_FREE;
            upd.amount     = hit_ent_ff.size;
            upd.merge_next = mn;
            upd.merge_prev = mp;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            ram_raddr = sh_k_ff;
            if (sw_v_ff) begin
               ram_we    = 1'b1;
               ram_waddr = sw_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (sh_cnt_ff != '0) begin
               sw_v_in    = 1'b1;
               sw_addr_in = sh_up_ff ? (sh_k_ff + IW'(1)) : (sh_k_ff - IW'(sh_dist_ff));
               sh_k_in    = sh_up_ff ? (sh_k_ff - IW'(1)) : (sh_k_ff + IW'(1));
               sh_cnt_in  = sh_cnt_ff - CW'(1);
            end else if (!sw_v_ff) begin
               state_in = S_FIX0;
            end
         end
         S_FIX0: begin
            ram_we    = 1'b1;
            ram_waddr = fix0_addr_ff;
            ram_wdata = fix0_ff;
            state_in  = fix1_en_ff ? S_FIX1 : S_RESP;
         end
         S_FIX1: begin
            ram_we    = 1'b1;
            ram_waddr = fix1_addr_ff;
            ram_wdata = fix1_ff;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = (status_ff == ffha_pkg::ST_OK) ? res_addr_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // heap write makes table one free block; only while idle, user-enforced
      if (csr_write_en) begin
         heap_in    = heap_clamped;
         ram_we     = 1'b1;
         ram_waddr  = '0;
         ram_wdata  = '{is_free: 1'b1, size: heap_clamped - SB'(HEADER_BYTES),
                        start: '0};
         upd.op     = ffha_pkg::SOP_INIT;
         upd.amount = heap_clamped - SB'(HEADER_BYTES);
         if (state_ff == S_INIT) begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         heap_ff      <= ffha_pkg::HEAP_DEFAULT_BYTES;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         sh_cnt_ff    <= '0;
         sw_v_ff      <= 1'b0;
         fix1_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_ff      <= heap_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         sh_cnt_ff    <= sh_cnt_in;
         sw_v_ff      <= sw_v_in;
         fix1_en_ff   <= fix1_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff       <= need_in;
      off_ff        <= off_in;
      pend_idx_ff   <= pend_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_ent_ff    <= hit_ent_in;
      prev_ent_ff   <= prev_ent_in;
      has_next_ff   <= has_next_in;
      sh_k_ff       <= sh_k_in;
      sh_up_ff      <= sh_up_in;
      sh_dist_ff    <= sh_dist_in;
      sw_addr_ff    <= sw_addr_in;
      fix0_addr_ff  <= fix0_addr_in;
      fix1_addr_ff  <= fix1_addr_in;
      fix0_ff       <= fix0_in;
      fix1_ff       <= fix1_in;
      status_ff     <= status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // statistics are live: the stats update lands before the response is loaded
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.addr             = rsp_addr_ff;
   assign rsp_chan.used_bytes       = used_total;
   assign rsp_chan.free_bytes       = free_total;
   assign rsp_chan.block_count      = ffha_pkg::STAT_COUNT_BITS'(blk_total);
   assign rsp_chan.free_block_count = ffha_pkg::STAT_COUNT_BITS'(fblk_total);
endmodule

[tb/tb_first_fit_heap_allocator_unit.sv]
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_unit;

   localparam int MAXB  = ffha_pkg::MAX_BLOCKS_DEF;
   localparam int HDR   = ffha_pkg::HEADER_BYTES_DEF;
   localparam int ALIGN = ffha_pkg::ALIGN_BYTES_DEF;
   localparam int OB    = ffha_pkg::OFFSET_BITS;
   localparam int OB1   = ffha_pkg::OFFSET_BITS + 1;
   localparam int SB    = ffha_pkg::SIZE_BITS;
   localparam int NB    = ffha_pkg::NEED_BITS;
   localparam int CB    = ffha_pkg::STAT_COUNT_BITS;

   typedef struct packed {
      logic [2:0]    status;
      logic [OB-1:0] addr;
      logic [SB-1:0] used_bytes;
      logic [SB-1:0] free_bytes;
      logic [CB-1:0] block_count;
      logic [CB-1:0] free_block_count;
   } heap_result_type;

   typedef struct {
      logic [OB:0]   start;
      logic [NB-1:0] size;
      bit            is_free;
   } blk_type;

   int unsigned fail_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the block list and the heap size,
   // works out each response when the request transaction is accepted.
   // ---------------------------------------------------------------------
   class heap_scoreboard;
      blk_type         blocks[$];
      longint          heap_limit;
      heap_result_type pending[$];
      int unsigned     n_checked;

      function void set_heap(input longint v);
         blk_type b;
         if (v < ffha_pkg::HEAP_MIN_BYTES) v = ffha_pkg::HEAP_MIN_BYTES;
         if (v > ffha_pkg::HEAP_MAX_BYTES) v = ffha_pkg::HEAP_MAX_BYTES;
         heap_limit = v;
         blocks.delete();
         b.start = '0; b.size = NB'(v - HDR); b.is_free = 1'b1;
         blocks.push_back(b);
      endfunction

      function ffha_pkg::status_type alloc(input longint sz, output longint addr);
         longint  need;
         blk_type tail;
         addr = 0;
         if (sz == 0) return ffha_pkg::ST_ZERO_SIZE;
         need = ((sz + ALIGN - 1) / ALIGN) * ALIGN;
         foreach (blocks[i]) begin
            if (blocks[i].is_free && blocks[i].size >= need) begin
               if (blocks[i].size >= need + HDR + ALIGN && blocks.size() < MAXB) begin
                  tail.start   = OB1'(blocks[i].start + HDR + need);
                  tail.size    = NB'(blocks[i].size - need - HDR);
                  tail.is_free = 1'b1;
                  blocks.insert(i + 1, tail);
                  blocks[i].size = NB'(need);
               end
               blocks[i].is_free = 1'b0;
               addr = blocks[i].start + HDR;
               return ffha_pkg::ST_OK;
            end
         end
         return ffha_pkg::ST_NO_MEMORY;
      endfunction

      function ffha_pkg::status_type release_blk(input longint off);
         int idx;
         idx = -1;
         if (off >= heap_limit) return ffha_pkg::ST_OUTSIDE;
         foreach (blocks[i])
            if (idx < 0 && blocks[i].start + HDR == off) idx = i;
         if (idx < 0) return ffha_pkg::ST_NOT_BLOCK;
         if (blocks[idx].is_free) return ffha_pkg::ST_DOUBLE;
         blocks[idx].is_free = 1'b1;
         if (idx + 1 < blocks.size() && blocks[idx+1].is_free) begin
            blocks[idx].size += NB'(HDR) + blocks[idx+1].size;
            blocks.delete(idx + 1);
         end
         if (idx > 0 && blocks[idx-1].is_free) begin
            blocks[idx-1].size += NB'(HDR) + blocks[idx].size;
            blocks.delete(idx);
         end
         return ffha_pkg::ST_OK;
      endfunction

      function void note_request(input logic t, input longint sz, input longint off);
         heap_result_type r;
         longint a, u, f;
         int fc;
         ffha_pkg::status_type s;
         a = 0;
         if (t == ffha_pkg::REQ_ALLOC) s = alloc(sz, a);
         else                          s = release_blk(off);
         u = 0; f = 0; fc = 0;
         foreach (blocks[i])
            if (blocks[i].is_free) begin f += blocks[i].size; fc++; end
            else u += blocks[i].size;
         r.status = s; r.addr = OB'(a); r.used_bytes = SB'(u); r.free_bytes = SB'(f);
         r.block_count = CB'(blocks.size()); r.free_block_count = CB'(fc);
         pending.push_back(r);
      endfunction

      task check_result(input heap_result_type got);
         heap_result_type w;
         n_checked++;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", got.status, -1);
            return;
         end
         w = pending.pop_front();
         if (got.status != w.status) report_mismatch("status", got.status, w.status);
         if (got.addr != w.addr) report_mismatch("addr", got.addr, w.addr);
         if (got.used_bytes != w.used_bytes)
            report_mismatch("used_bytes", got.used_bytes, w.used_bytes);
         if (got.free_bytes != w.free_bytes)
            report_mismatch("free_bytes", got.free_bytes, w.free_bytes);
         if (got.block_count != w.block_count)
            report_mismatch("block_count", got.block_count, w.block_count);
         if (got.free_block_count != w.free_block_count)
            report_mismatch("free_block_count", got.free_block_count, w.free_block_count);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [SB-1:0] csr_write_data = '0;

   ffha_req_if req_bus();
   ffha_rsp_if rsp_bus();

   first_fit_heap_allocator_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_bus.sink),
      .rsp_chan       (rsp_bus.source)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   heap_scoreboard sb = new();

   // idling switches; quiet_mode disables bursts near the end of the run
   bit quiet_mode = 0;
   bit hold_rsp   = 0;
   int unsigned n_sent = 0;
   int unsigned rsp_idle = 0;

   initial begin
      req_bus.valid = 0; req_bus.req_type = ffha_pkg::REQ_ALLOC;
      req_bus.req_size = '0; req_bus.req_addr = '0;
      rsp_bus.ready = 0;
   end

   // Response side: ready drops in short random bursts, plus a long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result({rsp_bus.status, rsp_bus.addr, rsp_bus.used_bytes,
                             rsp_bus.free_bytes, rsp_bus.block_count,
                             rsp_bus.free_block_count});
         if (hold_rsp) begin
            rsp_bus.ready <= 0;
         end else if (rsp_idle != 0) begin
            rsp_idle--;
            rsp_bus.ready <= 0;
         end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            rsp_idle = $urandom_range(0, 2);
            rsp_bus.ready <= 0;
         end else begin
            rsp_bus.ready <= 1;
         end
      end
   end

   // Drive one request transaction and wait for its acceptance.
   task automatic send_request(input logic t, input logic [SB-1:0] sz,
                               input logic [OB-1:0] off);
      int gap;
      if (!quiet_mode && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1;
      req_bus.req_type <= t;
      req_bus.req_size <= sz;
      req_bus.req_addr <= off;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(t, sz, off);
      n_sent++;
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_bus.valid <= 0;
      while (sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (2 * MAXB + 20) @(posedge clock);
   endtask

   task automatic write_heap(input logic [SB-1:0] v);
      csr_write_en   <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 0;
      sb.set_heap(v);
      @(posedge clock);
   endtask

   // payload offset of a random allocated block, or of a random block when none is allocated
   function automatic logic [OB-1:0] pick_offset();
      int k;
      int m;
      m = sb.blocks.size();
      k = $urandom_range(0, m - 1);
      for (int j = 0; j < m; j++)
         if (!sb.blocks[(k + j) % m].is_free)
            return OB'(sb.blocks[(k + j) % m].start + HDR);
      return OB'(sb.blocks[k].start + HDR);
   endfunction

   function automatic logic [SB-1:0] random_size();
      case ($urandom_range(0, 9))
         0:       return SB'($urandom_range(0, 2 ** SB - 1));
         1:       return SB'($urandom_range(1, 16));
         2,3:     return SB'($urandom_range(1, 1 << 20));
         default: return SB'($urandom_range(1, 4096));
      endcase
   endfunction

   task automatic random_phase(input int count);
      int sel;
      logic [OB-1:0] off;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            send_request(ffha_pkg::REQ_ALLOC, random_size(), OB'($urandom));
         end else if (sel < 88) begin
            send_request(ffha_pkg::REQ_FREE, SB'($urandom), pick_offset());
         end else begin
            case ($urandom_range(0, 3))
               0: off = OB'($urandom);                            // arbitrary
               1: off = pick_offset() + OB'(ALIGN);               // not a block start
               2: off = OB'(sb.blocks[$urandom_range(0, sb.blocks.size()-1)].start
                            + HDR);                               // may be double free
               default: off = OB'(sb.heap_limit + $urandom_range(0, 255));
            endcase
            send_request(ffha_pkg::REQ_FREE, SB'($urandom), off);
         end
      end
   endtask

   initial begin
      sb.set_heap(ffha_pkg::HEAP_DEFAULT_BYTES);
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: field extremes and every status but ST_OUTSIDE
      send_request(ffha_pkg::REQ_ALLOC, 25'd0, 24'd0);
      send_request(ffha_pkg::REQ_ALLOC, 25'd1, 24'd0);
      send_request(ffha_pkg::REQ_ALLOC, 25'd16, '1);
      send_request(ffha_pkg::REQ_ALLOC, 25'd17, 24'd0);
      send_request(ffha_pkg::REQ_ALLOC, 25'h1FFFFFF, 24'd0);
      send_request(ffha_pkg::REQ_ALLOC, 25'd16777216, 24'd0);
      send_request(ffha_pkg::REQ_FREE, '1, 24'd0);
      send_request(ffha_pkg::REQ_FREE, '0, 24'hFFFFFF);
      send_request(ffha_pkg::REQ_FREE, '0, 24'd33);
      send_request(ffha_pkg::REQ_FREE, '0, 24'd32 + 24'd32 + 24'd16);
      send_request(ffha_pkg::REQ_FREE, '0, 24'd32);
      send_request(ffha_pkg::REQ_FREE, '0, 24'd32);
      send_request(ffha_pkg::REQ_FREE, '0, 24'd80);
      send_request(ffha_pkg::REQ_FREE, '0, 24'd32 + 24'd48 + 24'd32);
      drain();

      // fill the table to its limit so the last fit is handed out whole
      write_heap(25'd0);
      for (int n = 0; n < MAXB + 2; n++)
         send_request(ffha_pkg::REQ_ALLOC, SB'($urandom_range(1, 64)), 24'd0);
      send_request(ffha_pkg::REQ_ALLOC, 25'd4194304, 24'd0);
      random_phase(150);
      drain();

      // long hold-off at the receiver while requests keep coming
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         random_phase(20);
      join
      drain();

      write_heap(25'h1FFFFFF);
      random_phase(400);
      drain();

      write_heap(25'd5000000);
      random_phase(400);
      drain();

      write_heap(25'd4194304);
      random_phase(350);
      drain();

      quiet_mode = 1;
      write_heap(25'd16777216);
      random_phase(300);
      drain();

      $display("Covered %0d requests over six heap settings, a full table and a long stall.",
               n_sent);
      $display("%0d responses checked.", sb.n_checked);
      if (fail_count == 0 && sb.pending.size() == 0) begin
         $display("tb_first_fit_heap_allocator_unit: PASS");
      end else begin
         $display("tb_first_fit_heap_allocator_unit: FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_first_fit_heap_allocator_unit: FAIL");
      $finish;
   end

endmodule

[filelist.f]
rtl/ffha_pkg.sv
rtl/ffha_req_if.sv
rtl/ffha_rsp_if.sv
rtl/ffha_ram.sv
rtl/ffha_stats.sv
rtl/first_fit_heap_allocator_unit.sv
tb/tb_first_fit_heap_allocator_unit.sv
